### rtl/mdhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhc_pkg
// shared types and codes of the magazine depot handle cache
// ----------------------------------------------------------------------------
package mdhc_pkg;

    typedef enum logic [1:0] {
        ST_ALLOC_HIT    = 2'd0,
        ST_ALLOC_MISS   = 2'd1,
        ST_FREE_ABSORB  = 2'd2,
        ST_FREE_REFUSE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DONE
    } fsm_state_t;

    // action chosen by the datapath for one pass
    typedef enum logic [2:0] {
        ACT_POP,
        ACT_PUSH,
        ACT_SWAP,
        ACT_DEPOT,
        ACT_CREATE,
        ACT_FAIL
    } action_t;

    typedef struct packed {
        logic start;    // latch request and update counters
        logic step;     // apply the chosen action
        logic finish;   // result taken: clear the output valid
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    pass_last;
    } stat_t;

    localparam int unsigned MAX_PASSES = 4;

endpackage

### rtl/mdhc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhc_ctrl
// request sequencer: one decision pass per cycle, then slot read, then result
// ----------------------------------------------------------------------------
module mdhc_ctrl
    import mdhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_free,
    output cmd_t  cmd,
    input  stat_t stat
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.action == ACT_POP)
                begin
                    state_next = S_READ;
                end
                else if (stat.action == ACT_PUSH || stat.action == ACT_FAIL
                         || stat.pass_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        cmd.start  = (state_reg == S_IDLE) && in_valid;
        cmd.step   = (state_reg == S_DECIDE);
        cmd.finish = (state_reg == S_DONE) && out_free;
    end

endmodule

### rtl/mdhc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhc_datapath
// magazine state, depot stacks, slot memory and counters
// ----------------------------------------------------------------------------
module mdhc_datapath
    import mdhc_pkg::*;
#(
    parameter int MAG_ROUNDS  = 32,
    parameter int NUM_MAGS    = 16,
    parameter int HANDLE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        req_type,
    input  logic [31:0] handle,
    input  logic [15:0] object_size,
    output logic [1:0]  status,
    output logic [31:0] out_handle,
    output logic [31:0] bytes_outstanding,
    output logic [31:0] alloc_count,
    output logic [31:0] free_count
);

    localparam int MW = $clog2(NUM_MAGS + 1);   // magazine number incl. none
    localparam int MI = $clog2(NUM_MAGS);
    localparam int FW = $clog2(MAG_ROUNDS + 1);
    localparam int RI = $clog2(MAG_ROUNDS);
    localparam int AW = MI + RI;
    localparam int SW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam logic [MW-1:0] NO_MAG = MW'(NUM_MAGS);
    localparam logic [FW-1:0] FULL = FW'(MAG_ROUNDS);

    logic [SW-1:0] slots_mem [2**AW];
    logic [MI-1:0] full_mem  [NUM_MAGS];
    logic [MI-1:0] empty_mem [NUM_MAGS];
    logic [FW-1:0] fill_reg  [NUM_MAGS];

    logic [MW-1:0] loaded_reg, previous_reg;
    logic [MW-1:0] full_depth_reg, empty_depth_reg, made_reg;
    logic [31:0]   bytes_reg, allocs_reg, frees_reg;
    logic          req_reg;
    logic [SW-1:0] handle_reg, rd_reg;
    logic [1:0]    pass_reg;
    logic [1:0]    status_reg;
    logic          rd_hit_reg;

    logic          ld_ok, pv_ok;
    logic [FW-1:0] ld_fill, pv_fill;
    action_t       act;
    logic [AW-1:0] slot_addr;

    assign ld_ok   = loaded_reg < NO_MAG;
    assign pv_ok   = previous_reg < NO_MAG;
    assign ld_fill = ld_ok ? fill_reg[loaded_reg[MI-1:0]] : '0;
    assign pv_fill = pv_ok ? fill_reg[previous_reg[MI-1:0]] : '0;

    always_comb
    begin
        act = ACT_FAIL;
        if (!req_reg)
        begin
            priority if (ld_ok && ld_fill != '0)               act = ACT_POP;
            else if (pv_ok && pv_fill == FULL)                  act = ACT_SWAP;
            else if (full_depth_reg != '0)                      act = ACT_DEPOT;
            else                                                act = ACT_FAIL;
        end
        else
        begin
            priority if (ld_ok && ld_fill < FULL)               act = ACT_PUSH;
            else if (pv_ok && pv_fill == '0)                    act = ACT_SWAP;
            else if (empty_depth_reg != '0)                     act = ACT_DEPOT;
            else if (made_reg < NO_MAG)                         act = ACT_CREATE;
            else                                                act = ACT_FAIL;
        end
    end

    assign stat.action    = act;
    assign stat.pass_last = (pass_reg == 2'(MAX_PASSES - 1));

    // pop address uses fill minus one, push uses fill
    assign slot_addr = {loaded_reg[MI-1:0],
                        (act == ACT_POP) ? RI'(ld_fill - 1'b1) : RI'(ld_fill)};

    always_ff @(posedge clk)
    begin
        if (cmd.step && act == ACT_PUSH)
        begin
            slots_mem[slot_addr] <= handle_reg;
        end
        // popped handle is captured once and held until the next pop
        if (cmd.step && act == ACT_POP)
        begin
            rd_reg <= slots_mem[slot_addr];
        end
        if (cmd.step && act == ACT_DEPOT && !req_reg && pv_ok
            && empty_depth_reg < NO_MAG)
        begin
            empty_mem[empty_depth_reg[MI-1:0]] <= previous_reg[MI-1:0];
        end
        if (cmd.step && act == ACT_DEPOT && req_reg && pv_ok
            && full_depth_reg < NO_MAG)
        begin
            full_mem[full_depth_reg[MI-1:0]] <= previous_reg[MI-1:0];
        end
        if (cmd.step && act == ACT_CREATE && empty_depth_reg < NO_MAG)
        begin
            empty_mem[empty_depth_reg[MI-1:0]] <= made_reg[MI-1:0];
        end
        if (cmd.start)
        begin
            req_reg    <= req_type;
            handle_reg <= handle[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MAGS; i++)
            begin
                fill_reg[i] <= '0;
            end
            loaded_reg      <= NO_MAG;
            previous_reg    <= NO_MAG;
            full_depth_reg  <= '0;
            empty_depth_reg <= '0;
            made_reg        <= '0;
            bytes_reg       <= '0;
            allocs_reg      <= '0;
            frees_reg       <= '0;
            pass_reg        <= '0;
            status_reg      <= ST_ALLOC_MISS;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                pass_reg   <= '0;
                rd_hit_reg <= 1'b0;
                if (!req_type)
                begin
                    allocs_reg <= allocs_reg + 32'd1;
                    if (bytes_reg > (32'hFFFF_FFFF - {16'd0, object_size}))
                        bytes_reg <= 32'hFFFF_FFFF;
                    else
                        bytes_reg <= bytes_reg + {16'd0, object_size};
                end
                else
                begin
                    frees_reg <= frees_reg + 32'd1;
                    if (bytes_reg > {16'd0, object_size})
                        bytes_reg <= bytes_reg - {16'd0, object_size};
                    else
                        bytes_reg <= '0;
                end
            end
            if (cmd.step)
            begin
                pass_reg <= pass_reg + 2'd1;
                unique case (act)
                    ACT_POP:
                    begin
                        fill_reg[loaded_reg[MI-1:0]] <= ld_fill - 1'b1;
                        status_reg <= ST_ALLOC_HIT;
                        rd_hit_reg <= 1'b1;
                    end
                    ACT_PUSH:
                    begin
                        fill_reg[loaded_reg[MI-1:0]] <= ld_fill + 1'b1;
                        status_reg <= ST_FREE_ABSORB;
                    end
                    ACT_SWAP:
                    begin
                        loaded_reg   <= previous_reg;
                        previous_reg <= loaded_reg;
                    end
                    ACT_DEPOT:
                    begin
                        previous_reg <= loaded_reg;
                        if (!req_reg)
                        begin
                            full_depth_reg <= full_depth_reg - 1'b1;
                            loaded_reg <= MW'(full_mem[MI'(full_depth_reg - 1'b1)]);
                            if (pv_ok && empty_depth_reg < NO_MAG)
                                empty_depth_reg <= empty_depth_reg + 1'b1;
                        end
                        else
                        begin
                            empty_depth_reg <= empty_depth_reg - 1'b1;
                            loaded_reg <= MW'(empty_mem[MI'(empty_depth_reg - 1'b1)]);
                            if (pv_ok && full_depth_reg < NO_MAG)
                                full_depth_reg <= full_depth_reg + 1'b1;
                        end
                    end
                    ACT_CREATE:
                    begin
                        fill_reg[made_reg[MI-1:0]] <= '0;
                        made_reg <= made_reg + 1'b1;
                        if (empty_depth_reg < NO_MAG)
                            empty_depth_reg <= empty_depth_reg + 1'b1;
                    end
                    ACT_FAIL:
                    begin
                        status_reg <= req_reg ? ST_FREE_REFUSE : ST_ALLOC_MISS;
                    end
                    default:
                    begin
                        status_reg <= ST_ALLOC_MISS;
                    end
                endcase
                if (act != ACT_POP && act != ACT_PUSH && act != ACT_FAIL
                    && stat.pass_last)
                begin
                    status_reg <= req_reg ? ST_FREE_REFUSE : ST_ALLOC_MISS;
                end
            end
        end
    end

    // result fields, held stable in the done state
    assign status            = status_reg;
    assign out_handle        = rd_hit_reg ? 32'(rd_reg) : 32'd0;
    assign bytes_outstanding = bytes_reg;
    assign alloc_count       = allocs_reg;
    assign free_count        = frees_reg;

endmodule

### rtl/magazine_depot_handle_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magazine_depot_handle_cache_core
// handle cache with loaded and previous magazines and a depot
// ----------------------------------------------------------------------------
// One item is taken at a time. After acceptance the sequencer runs one
// decision pass per cycle against the magazine state (at most four passes:
// swap, depot fetch or magazine creation, then push or pop); an alloc hit
// also passes through a slot read state. No new item is taken until the
// result has been taken and the block is back in idle. object_size is
// written through the apb port at address 0; the user must write it only
// while the block is idle, which the block itself does not enforce.
module magazine_depot_handle_cache_core
    import mdhc_pkg::*;
#(
    parameter int MAG_ROUNDS  = 32,
    parameter int NUM_MAGS    = 16,
    parameter int HANDLE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] out_handle,
    output logic [31:0] bytes_outstanding,
    output logic [31:0] alloc_count,
    output logic [31:0] free_count
);

    logic [15:0] object_size_reg;
    cmd_t        cmd;
    stat_t       stat;
    logic        done_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, object_size_reg} : 32'd0;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_size_reg <= 16'd64;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            object_size_reg <= pwdata[15:0];
        end
    end

    mdhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (done_reg && !out_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    mdhc_datapath #(
        .MAG_ROUNDS  (MAG_ROUNDS),
        .NUM_MAGS    (NUM_MAGS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_type          (req_type),
        .handle            (handle),
        .object_size       (object_size_reg),
        .status            (status),
        .out_handle        (out_handle),
        .bytes_outstanding (bytes_outstanding),
        .alloc_count       (alloc_count),
        .free_count        (free_count)
    );

    // result valid tracks the sequencer's done state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            done_reg <= 1'b0;
        end
        else if (in_stall && !done_reg && (
                 (cmd.step && (stat.action == ACT_PUSH || stat.action == ACT_FAIL
                  || (stat.pass_last && stat.action != ACT_POP)))
                 || (!cmd.step && !cmd.start)))
        begin
            done_reg <= 1'b1;
        end
    end

    assign out_valid = done_reg;

endmodule

### rtl/mdhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhc_checker
// port level checks of the handle cache
// ----------------------------------------------------------------------------
module mdhc_checker
    import mdhc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] out_handle
);

    // a result is never shown while the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result valid while input open");

    // only alloc hits carry a handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ALLOC_HIT) |-> out_handle == 32'd0)
        else $error("handle on non-hit result");

    // an accepted item blocks further input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted back to back");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(status))
        else $error("stalled result changed");

endmodule

bind magazine_depot_handle_cache_core mdhc_checker u_mdhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_handle (out_handle)
);
